>>> sv/dotq_pkg.sv
// Shared types and constants for the deadline-ordered timer queue.
`default_nettype none

package dotq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 48;
  localparam int HANDLE_BITS = 16;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // Request codes carried on in_req_type.
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_POLL   = 1'b1
  } req_type_t;

  // What every cell does on an execute cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_t;

  // One queued task.
  typedef struct packed {
    logic [TIME_BITS-1:0]   deadline;
    logic [HANDLE_BITS-1:0] handle;
    logic                   nestable;
  } entry_t;

  // Control broadcast from the top level to one cell.
  typedef struct packed {
    cell_op_t op;
    logic     occupied;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/dotq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`default_nettype none

module dotq_cell (
  input  wire                      clk,
  input  wire dotq_pkg::cell_ctl_t ctl,
  input  wire dotq_pkg::entry_t    new_entry,
  input  wire dotq_pkg::entry_t    left_entry,
  input  wire dotq_pkg::entry_t    right_entry,
  input  wire                      left_keep,
  output logic                     keep,
  output dotq_pkg::entry_t         entry
);

  dotq_pkg::entry_t entry_r;
  dotq_pkg::entry_t entry_nxt;

  // An occupied cell whose deadline is not later than the new one stays put.
  assign keep = ctl.occupied && (entry_r.deadline <= new_entry.deadline);

  // On insert the first moving cell takes the new item, the rest shift right.
  // On pop every cell takes its right neighbor's entry; the last one keeps its own.
  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      dotq_pkg::CELL_INSERT: begin
        if (keep) begin
          entry_nxt = entry_r;
        end else if (!left_keep) begin
          entry_nxt = left_entry;
        end else begin
          entry_nxt = new_entry;
        end
      end
      dotq_pkg::CELL_POP: begin
        entry_nxt = right_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

>>> sv/deadline_ordered_timer_queue.sv
// Top level of the deadline-ordered timer queue: request capture, cell chain and result.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-------------------------------
//   input   | in_req_type, in_task_handle, in_deadline | taken when start && !busy
//           | in_is_nestable, in_now_time, in_loop_nested |
//   result  | out_accepted ... out_next_deadline      | one-cycle strobe on out_valid
//
// Each item is first captured into the request registers; then, with busy high,
// the whole cell chain compares in parallel and shifts by one place. The result
// strobes in the cycle after that, which overlaps the capture of the next item.
// Reset clears the entry count and the handshake state; entry contents are not
// cleared. The receiver cannot stall: a result is shown for exactly one cycle.
`default_nettype none

module deadline_ordered_timer_queue (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire                                 in_req_type,
  input  wire  [dotq_pkg::HANDLE_BITS-1:0]    in_task_handle,
  input  wire  [dotq_pkg::TIME_BITS-1:0]      in_deadline,
  input  wire                                 in_is_nestable,
  input  wire  [dotq_pkg::TIME_BITS-1:0]      in_now_time,
  input  wire                                 in_loop_nested,
  output logic                                out_valid,
  output logic                                out_accepted,
  output logic                                out_became_head,
  output logic                                out_task_valid,
  output logic [dotq_pkg::HANDLE_BITS-1:0]    out_task_out,
  output logic                                out_run_now,
  output logic                                out_next_valid,
  output logic [dotq_pkg::TIME_BITS-1:0]      out_next_deadline
);

  localparam int D = dotq_pkg::QUEUE_DEPTH;

  // Captured request.
  logic                               busy_r;
  dotq_pkg::req_type_t                req_r;
  dotq_pkg::entry_t                   new_r;
  logic [dotq_pkg::TIME_BITS-1:0]     now_r;
  logic                               nested_r;
  logic [dotq_pkg::CNT_BITS-1:0]      count_r;
  logic [dotq_pkg::CNT_BITS-1:0]      count_nxt;

  // Result registers.
  logic                               out_valid_r;
  logic                               accepted_r, accepted_nxt;
  logic                               head_r, head_nxt;
  logic                               task_valid_r, task_valid_nxt;
  logic [dotq_pkg::HANDLE_BITS-1:0]   task_out_r, task_out_nxt;
  logic                               run_now_r, run_now_nxt;
  logic                               next_valid_r, next_valid_nxt;
  logic [dotq_pkg::TIME_BITS-1:0]     next_dl_r, next_dl_nxt;

  // Chain wiring.
  dotq_pkg::cell_op_t                 op;
  dotq_pkg::entry_t                   cell_q [D];
  logic                               keep_q [D];
  logic                               full, empty, due, accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;
  assign full   = (count_r == dotq_pkg::CNT_BITS'(D));
  assign empty  = (count_r == '0);
  assign due    = (cell_q[0].deadline <= now_r);

  // Capture the request; the time argument and the flag are both kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r        <= dotq_pkg::req_type_t'(in_req_type);
      new_r.deadline <= in_deadline;
      new_r.handle   <= in_task_handle;
      new_r.nestable <= in_is_nestable;
      now_r        <= in_now_time;
      nested_r     <= in_loop_nested;
    end
  end

  // Decide the chain operation and the result on the execute cycle.
  always_comb begin
    op             = dotq_pkg::CELL_HOLD;
    count_nxt      = count_r;
    accepted_nxt   = 1'b0;
    head_nxt       = 1'b0;
    task_valid_nxt = 1'b0;
    task_out_nxt   = '0;
    run_now_nxt    = 1'b0;
    next_valid_nxt = 1'b0;
    next_dl_nxt    = '0;
    if (busy_r) begin
      case (req_r)
        dotq_pkg::REQ_INSERT: begin
          if (!full) begin
            op           = dotq_pkg::CELL_INSERT;
            count_nxt    = count_r + 1'b1;
            accepted_nxt = 1'b1;
            head_nxt     = !keep_q[0];
          end
        end
        dotq_pkg::REQ_POLL: begin
          if (!empty) begin
            if (!due) begin
              next_valid_nxt = 1'b1;
              next_dl_nxt    = cell_q[0].deadline;
            end else begin
              op             = dotq_pkg::CELL_POP;
              count_nxt      = count_r - 1'b1;
              task_valid_nxt = 1'b1;
              task_out_nxt   = cell_q[0].handle;
              run_now_nxt    = !nested_r || cell_q[0].nestable;
              if (count_r > dotq_pkg::CNT_BITS'(1)) begin
                next_valid_nxt = 1'b1;
                next_dl_nxt    = cell_q[1].deadline;
              end
            end
          end
        end
        default: begin
          op = dotq_pkg::CELL_HOLD;
        end
      endcase
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result strobe and fields.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    accepted_r   <= accepted_nxt;
    head_r       <= head_nxt;
    task_valid_r <= task_valid_nxt;
    task_out_r   <= task_out_nxt;
    run_now_r    <= run_now_nxt;
    next_valid_r <= next_valid_nxt;
    next_dl_r    <= next_dl_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = accepted_r;
  assign out_became_head   = head_r;
  assign out_task_valid    = task_valid_r;
  assign out_task_out      = task_out_r;
  assign out_run_now       = run_now_r;
  assign out_next_valid    = next_valid_r;
  assign out_next_deadline = next_dl_r;

  // The row of cells, head at index zero.
  for (genvar i = 0; i < D; i++) begin : g_cell
    dotq_pkg::cell_ctl_t ctl;
    dotq_pkg::entry_t    left_e;
    dotq_pkg::entry_t    right_e;
    logic                left_k;

    assign ctl = {op, (dotq_pkg::CNT_BITS'(i) < count_r)};

    if (i == 0) begin : g_first
      assign left_e = new_r;
      assign left_k = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_k = keep_q[i-1];
    end

    if (i == D - 1) begin : g_last
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    dotq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_r),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_keep   (left_k),
      .keep        (keep_q[i]),
      .entry       (cell_q[i])
    );
  end

`ifndef SYNTHESIS
  // The count never goes past the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dotq_pkg::CNT_BITS'(D))
    else $error("entry count above queue depth");

  // Every execute cycle is followed by exactly one result strobe.
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> out_valid_r)
    else $error("execute cycle without result");

  // The execute cycle lasts one cycle.
  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r)
    else $error("busy held for more than one cycle");

  // The count moves only on an execute cycle.
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> $stable(count_r))
    else $error("entry count changed while idle");

  // An insert result and a popped task never appear together.
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(accepted_r && task_valid_r))
    else $error("result marks both insert and pop");
`endif

endmodule

`default_nettype wire
